@@ rtl/srlh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlh_pkg: shared types and constants
// Action codes, the result record and the depth of the result queue for the
// sequential run-length histogram.
// ----------------------------------------------------------------------------
package srlh_pkg;

  // request action codes
  typedef enum logic [1:0] {
    ActRecord = 2'd0,
    ActEnd    = 2'd1,
    ActRead   = 2'd2
  } action_e;

  // one result record
  typedef struct packed {
    logic [31:0] closed_length;
    logic [31:0] current_length;
    logic [31:0] bin_count;
  } result_t;

  // result queue depth and occupancy width
  localparam int unsigned OutqDepth = 3;
  localparam int unsigned OutqPtrW  = 2;
  localparam int unsigned OutqCntW  = 2;

endpackage
`default_nettype wire

@@ rtl/sequential_run_length_histogram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sequential_run_length_histogram: run-length histogram of block I/O
// Tracks the current sequential run of I/O records and counts closed runs
// by length in a saturating histogram held in a RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  request  | in_valid_i / in_ready_o  | action, process_id, block_address,
//           |                          | is_write, bin_index
//  result   | out_valid_o/ out_ready_i | closed_length, current_length,
//           |                          | bin_count
//  config   | cfg_we_i                 | cfg_wdata_i (address stride)
//
// One request per cycle sustained while the result queue has room. A request
// is decoded and the run state updated in the accept cycle while the histogram
// RAM read is issued; the next cycle does the saturating increment and
// write-back, forwarding the previous write when both hit the same bin.
// Results pass through the histogram stage register and then a three-entry
// queue that absorbs output stalls.
// After reset a clearing pass zeroes all MAX_RUN+1 bins, one per cycle, and
// no request is accepted until it finishes.
// ----------------------------------------------------------------------------
module sequential_run_length_histogram #(
  parameter int unsigned MAX_RUN     = 2048,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] process_id_i,
  input  wire logic [31:0] block_address_i,
  input  wire logic        is_write_i,
  input  wire logic [11:0] bin_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      closed_length_o,
  output logic [31:0]      current_length_o,
  output logic [31:0]      bin_count_o
);
  import srlh_pkg::*;

  localparam int unsigned Bins  = MAX_RUN + 1;
  localparam int unsigned AddrW = $clog2(Bins);
  localparam logic [31:0] MaxRunW = 32'(MAX_RUN);

  typedef enum logic [1:0] {
    OpNone,
    OpInc,
    OpRead
  } hist_op_e;

  // configuration
  logic [7:0]  stride_q;

  // run tracker
  logic        run_open_q, run_open_d;
  logic [31:0] run_pid_q, run_pid_d;
  logic [31:0] exp_addr_q, exp_addr_d;
  logic        run_dir_q, run_dir_d;
  logic [31:0] run_len_q, run_len_d;

  // clearing pass
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // histogram stage
  logic             s1_v_q;
  hist_op_e         s1_op_q, op_d;
  logic [AddrW-1:0] s1_addr_q, addr_d;
  logic [31:0]      s1_closed_q, closed_d;
  logic [31:0]      s1_current_q;

  // write forwarding
  logic                   fwd_v_q;
  logic [AddrW-1:0]       fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_data_q;

  logic                   accept;
  logic                   cont;
  logic [31:0]            idx_w;
  logic [AddrW-1:0]       close_bin;
  logic [COUNT_WIDTH-1:0] ram_rdata, cur_count, inc_count;
  logic [31:0]            clip_count;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   hist_we;
  logic [OutqCntW-1:0]    q_count;
  logic [OutqCntW:0]      in_flight;
  result_t                push_res, out_res;

  // accept when the clearing pass is done and the queue has room for everything in flight
  assign in_flight  = {1'b0, q_count} + (OutqCntW + 1)'(s1_v_q);
  assign in_ready_o = !clr_busy_q && (in_flight < (OutqCntW + 1)'(OutqDepth));
  assign accept     = in_valid_i && in_ready_o;

  // stride register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q <= 8'd8;
    end else if (cfg_we_i) begin
      stride_q <= cfg_wdata_i;
    end
  end

  // run continuation test and bin of the open run
  assign cont = run_open_q && (run_pid_q == process_id_i) &&
                (run_dir_q == is_write_i) && (exp_addr_q == block_address_i);
  assign close_bin = (run_len_q != '0 && run_len_q <= MaxRunW) ?
                     AddrW'(run_len_q - 32'd1) : AddrW'(MAX_RUN);
  assign idx_w = 32'(bin_index_i);

  // run state next value and histogram operation
  always_comb begin
    run_open_d = run_open_q;
    run_pid_d  = run_pid_q;
    exp_addr_d = exp_addr_q;
    run_dir_d  = run_dir_q;
    run_len_d  = run_len_q;
    op_d       = OpNone;
    addr_d     = close_bin;
    closed_d   = '0;
    case (action_e'(action_i))
      ActRecord: begin
        if (cont) begin
          if (run_len_q != '1) begin
            run_len_d = run_len_q + 32'd1;
          end
          exp_addr_d = exp_addr_q + 32'(stride_q);
        end else begin
          if (run_open_q) begin
            closed_d = run_len_q;
            op_d     = OpInc;
          end
          run_open_d = 1'b1;
          run_pid_d  = process_id_i;
          run_dir_d  = is_write_i;
          run_len_d  = 32'd1;
          exp_addr_d = block_address_i + 32'(stride_q);
        end
      end
      ActEnd: begin
        if (run_open_q) begin
          closed_d   = run_len_q;
          op_d       = OpInc;
          run_open_d = 1'b0;
          run_len_d  = '0;
        end
      end
      ActRead: begin
        if (idx_w <= MaxRunW) begin
          op_d   = OpRead;
          addr_d = idx_w[AddrW-1:0];
        end
      end
      default: begin
        op_d = OpNone;
      end
    endcase
  end

  // run state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      run_pid_q  <= '0;
      exp_addr_q <= '0;
      run_dir_q  <= 1'b0;
      run_len_q  <= '0;
    end else if (accept) begin
      run_open_q <= run_open_d;
      run_pid_q  <= run_pid_d;
      exp_addr_q <= exp_addr_d;
      run_dir_q  <= run_dir_d;
      run_len_q  <= run_len_d;
    end
  end

  // histogram stage registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s1_op_q <= OpNone;
    end else begin
      s1_v_q  <= accept;
      s1_op_q <= accept ? op_d : OpNone;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q    <= addr_d;
      s1_closed_q  <= closed_d;
      s1_current_q <= run_open_d ? run_len_d : '0;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == AddrW'(MAX_RUN)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  // read-modify-write with forwarding of the write from the last edge
  assign cur_count = (fwd_v_q && fwd_addr_q == s1_addr_q) ? fwd_data_q : ram_rdata;
  assign inc_count = (cur_count != '1) ? cur_count + 1'b1 : cur_count;
  assign hist_we   = (s1_op_q == OpInc);

  assign ram_we    = clr_busy_q || hist_we;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_busy_q ? '0 : inc_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= hist_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= inc_count;
    end
  end

  srlh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (Bins),
    .ADDR_W(AddrW)
  ) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(addr_d),
    .rdata_o(ram_rdata)
  );

  // report count limited to 32 bits
  if (COUNT_WIDTH > 32) begin : g_clip
    assign clip_count = (|cur_count[COUNT_WIDTH-1:32]) ? '1 : cur_count[31:0];
  end else begin : g_noclip
    assign clip_count = 32'(cur_count);
  end

  // result assembly and queue
  always_comb begin
    push_res.closed_length  = s1_closed_q;
    push_res.current_length = s1_current_q;
    push_res.bin_count      = (s1_op_q == OpRead) ? clip_count : '0;
  end

  srlh_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s1_v_q),
    .push_data_i(push_res),
    .count_o    (q_count),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_res)
  );

  assign closed_length_o  = out_res.closed_length;
  assign current_length_o = out_res.current_length;
  assign bin_count_o      = out_res.bin_count;

endmodule
`default_nettype wire

@@ rtl/srlh_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlh_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module srlh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2049,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/srlh_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srlh_outq: result queue
// Small queue of finished results in front of the output handshake, so
// the pipeline keeps moving while the consumer stalls.
// ----------------------------------------------------------------------------
module srlh_outq (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire srlh_pkg::result_t              push_data_i,
  output logic      [srlh_pkg::OutqCntW-1:0]  count_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output srlh_pkg::result_t                   out_data_o
);
  import srlh_pkg::*;

  result_t               entry_q [OutqDepth];
  logic [OutqPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [OutqPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [OutqCntW-1:0]   cnt_q, cnt_d;
  logic                  pop;

  assign pop = out_valid_o && out_ready_i;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == OutqPtrW'(OutqDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == OutqPtrW'(OutqDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign count_o     = cnt_q;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sequential run-length histogram check
// Drives block I/O requests through the valid/ready request channel with
// random gaps and result stalls, tracks runs and histogram bins in a local
// tracker, and compares every result field with the oldest expected one.
// A directed table comes first, then random run-shaped traffic under
// several strides.
// ----------------------------------------------------------------------------
module testbench;
  import srlh_pkg::*;

  localparam int unsigned MaxRun    = 2048;
  localparam logic [1:0]  ActUnused = 2'd3;
  localparam int unsigned NumRows   = 25;
  localparam int unsigned MaxPrint  = 50;

  // one request as it goes on the wire
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] pid;
    logic [31:0] addr;
    logic        dir;
    logic [11:0] idx;
  } io_req_t;

  // directed row: request plus a hand-written result where one is given
  typedef struct packed {
    io_req_t req;
    logic    known;
    result_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] closed_length_o;
  logic [31:0] current_length_o;
  logic [31:0] bin_count_o;

  io_req_t     cur_req;
  logic        cur_known;
  result_t     cur_typed;
  bit          gaps_on;
  int unsigned err_count;
  result_t     length_reports_q [$];

  // local copy of the run tracker and histogram
  logic [7:0]  run_stride;
  bit          run_open;
  logic [31:0] run_pid;
  logic [31:0] next_addr;
  bit          run_dir;
  logic [31:0] run_len;
  logic [31:0] len_hist [0:MaxRun];

  dir_row_t dir_rows [NumRows] = '{
    '{'{ActEnd,    32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActUnused, 32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRead,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF}, 1'b1,
      '{32'd0, 32'd0, 32'd0}},
    '{'{ActRecord, 32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd1, 32'd0}},
    '{'{ActRecord, 32'h0, 32'h8, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd2, 32'd0}},
    '{'{ActRecord, 32'h0, 32'h10, 1'b1, 12'h0}, 1'b1, '{32'd2, 32'd1, 32'd0}},
    '{'{ActUnused, 32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd1, 32'd0}},
    '{'{ActRecord, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 12'hFFF}, 1'b1,
      '{32'd1, 32'd1, 32'd0}},
    '{'{ActRecord, 32'hFFFF_FFFF, 32'h7, 1'b1, 12'h0}, 1'b1,
      '{32'd0, 32'd2, 32'd0}},
    '{'{ActRecord, 32'hFFFF_FFFE, 32'hF, 1'b1, 12'h0}, 1'b1,
      '{32'd2, 32'd1, 32'd0}},
    '{'{ActEnd,    32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd1, 32'd0, 32'd0}},
    '{'{ActEnd,    32'h0, 32'h0, 1'b0, 12'h0}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'd1}, 1'b1, '{32'd0, 32'd0, 32'd2}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'd0}, 1'b1, '{32'd0, 32'd0, 32'd2}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'd2048}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'd2049}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'd2047}, 1'b1, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRecord, 32'd5, 32'd100, 1'b0, 12'h0}, 1'b0, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRecord, 32'd6, 32'd108, 1'b0, 12'h0}, 1'b0, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRecord, 32'd6, 32'd116, 1'b0, 12'h0}, 1'b0, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRead,   32'h0, 32'h0, 1'b0, 12'd0}, 1'b0, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRecord, 32'd6, 32'd124, 1'b0, 12'h0}, 1'b0, '{32'd0, 32'd0, 32'd0}},
    '{'{ActRecord, 32'd6, 32'd132, 1'b1, 12'h0}, 1'b0, '{32'd0, 32'd0, 32'd0}},
    '{'{ActEnd,    32'h0, 32'h0, 1'b0, 12'h0}, 1'b0, '{32'd0, 32'd0, 32'd0}}
  };

  sequential_run_length_histogram #(
    .MAX_RUN    (MaxRun),
    .COUNT_WIDTH(32)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (cur_req.action),
    .process_id_i    (cur_req.pid),
    .block_address_i (cur_req.addr),
    .is_write_i      (cur_req.dir),
    .bin_index_i     (cur_req.idx),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .closed_length_o (closed_length_o),
    .current_length_o(current_length_o),
    .bin_count_o     (bin_count_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #15ms;
    $display("Verification failed");
    $finish;
  end

  // mismatch report: one line, always counted
  task automatic flag_error(input string msg);
    if (err_count < MaxPrint) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // close the open run into its bin, return its length
  function automatic logic [31:0] close_open_run();
    logic [31:0] len;
    int unsigned bin;
    if (!run_open) return '0;
    len = run_len;
    bin = (len >= 1 && len <= MaxRun) ? len - 1 : MaxRun;
    if (len_hist[bin] != '1) len_hist[bin]++;
    run_open = 1'b0;
    run_len  = '0;
    return len;
  endfunction

  // run tracker: advance state for one request and form its result
  function automatic result_t predict_run_result(input io_req_t q);
    result_t res;
    res = '0;
    case (q.action)
      ActRecord: begin
        if (run_open && run_pid == q.pid && run_dir == q.dir && next_addr == q.addr) begin
          if (run_len != '1) run_len++;
          next_addr = next_addr + 32'(run_stride);
        end else begin
          res.closed_length = close_open_run();
          run_open  = 1'b1;
          run_pid   = q.pid;
          run_dir   = q.dir;
          run_len   = 32'd1;
          next_addr = q.addr + 32'(run_stride);
        end
      end
      ActEnd: begin
        res.closed_length = close_open_run();
      end
      ActRead: begin
        if (q.idx <= MaxRun) res.bin_count = len_hist[q.idx];
      end
      default: ;
    endcase
    res.current_length = run_open ? run_len : '0;
    return res;
  endfunction

  // accept and compare, sampled at the rising edge
  always @(posedge clk_i) begin : result_check
    result_t want;
    result_t pred;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (length_reports_q.size() == 0) begin
          flag_error($sformatf("result with none pending: closed=%0d cur=%0d count=%0d",
                               closed_length_o, current_length_o, bin_count_o));
        end else begin
          want = length_reports_q.pop_front();
          if (closed_length_o !== want.closed_length)
            flag_error($sformatf("closed_length got %0d want %0d",
                                 closed_length_o, want.closed_length));
          if (current_length_o !== want.current_length)
            flag_error($sformatf("current_length got %0d want %0d",
                                 current_length_o, want.current_length));
          if (bin_count_o !== want.bin_count)
            flag_error($sformatf("bin_count got %0d want %0d",
                                 bin_count_o, want.bin_count));
        end
      end
      if (in_valid_i && in_ready_o) begin
        pred = predict_run_result(cur_req);
        length_reports_q.push_back(cur_known ? cur_typed : pred);
      end
    end
  end

  // result side stalls
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        if (gaps_on) hold = pick_gap();
      end
    end
  end

  // send one request, called and returning at a falling edge
  task automatic put_req(input io_req_t q, input logic known = 1'b0,
                         input result_t typed = '0);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_req    <= q;
    cur_known  <= known;
    cur_typed  <= typed;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // stop sending and wait until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (length_reports_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // stride register write while idle
  task automatic write_stride(input logic [7:0] value);
    drain();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    run_stride = value;
  endtask

  // random traffic shaped as runs, with breaks, reads and noise
  task automatic send_random_mix(input int unsigned target);
    int unsigned sent;
    int unsigned r;
    int unsigned len;
    logic [31:0] pid;
    logic [31:0] base;
    logic        dir;
    io_req_t     q;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      q = io_req_t'{ActRecord, $urandom, $urandom, 1'($urandom), 12'($urandom)};
      if (r < 62) begin
        // well-formed run
        pid  = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(1, 4)) : $urandom;
        base = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 4095));
        dir  = 1'($urandom);
        len  = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
        for (int unsigned k = 0; k < len; k++) begin
          put_req(io_req_t'{ActRecord, pid, base + 32'(k) * 32'(run_stride), dir,
                            12'($urandom)});
        end
        sent += len;
        if ($urandom_range(0, 4) == 0) begin
          q.action = ActEnd;
          put_req(q);
          sent++;
        end
      end else if (r < 74) begin
        // continue the open run, sometimes with one field off
        q.pid  = run_pid;
        q.addr = next_addr;
        q.dir  = run_dir;
        case ($urandom_range(0, 3))
          0: q.pid = q.pid ^ (32'd1 << $urandom_range(0, 31));
          1: q.dir = ~q.dir;
          2: q.addr = q.addr ^ (32'd1 << $urandom_range(0, 31));
          default: ;
        endcase
        put_req(q);
        sent++;
      end else if (r < 89) begin
        // bin read, mostly low bins
        q.action = ActRead;
        r = $urandom_range(0, 9);
        if (r < 7) q.idx = 12'($urandom_range(0, 15));
        else if (r < 9) q.idx = 12'($urandom_range(0, MaxRun));
        else q.idx = 12'($urandom_range(0, 4095));
        put_req(q);
        sent++;
      end else if (r < 96) begin
        q.action = ActEnd;
        put_req(q);
        sent++;
      end else begin
        // unused action, ignored by the block
        q.action = ActUnused;
        put_req(q);
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    logic [7:0] phase_stride [6];
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    cur_req     = '0;
    cur_known   = 1'b0;
    cur_typed   = '0;
    gaps_on     = 1'b0;
    err_count   = 0;
    run_stride  = 8'd8;
    run_open    = 1'b0;
    run_pid     = '0;
    next_addr   = '0;
    run_dir     = 1'b0;
    run_len     = '0;
    foreach (len_hist[i]) len_hist[i] = '0;
    phase_stride = '{8'd1, 8'd0, 8'($urandom_range(2, 254)),
                     8'($urandom_range(2, 254)), 8'd255, 8'd8};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table at reset stride
    gaps_on = 1'b1;
    foreach (dir_rows[i]) put_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].res);

    // random phases over several strides, one without idling
    foreach (phase_stride[p]) begin
      write_stride(phase_stride[p]);
      gaps_on = (p != 3);
      send_random_mix(120);
      drain();
      send_random_mix(122);
    end

    drain();
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
